[rtl/ure_pkg.sv]
package ure_pkg;

  localparam int VALUE_W  = 64;
  localparam int DIGIT_W  = 4;
  localparam int CHAR_W   = 8;
  localparam int CFG_IDX_W = 2;

  // quotient bits produced by the divider in one clock
  localparam int DIV_STEP_BITS = 8;

  localparam int MAX_RADIX_DEF  = 16;
  localparam int MAX_DIGITS_DEF = 64;
  localparam int RADIX_RESET    = 10;

  // "01234567" and "89abcdef", digit zero in the lowest byte
  localparam logic [VALUE_W-1:0] CHARS_LO_RESET = 64'h3736_3534_3332_3130;
  localparam logic [VALUE_W-1:0] CHARS_HI_RESET = 64'h6665_6463_6261_3938;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RADIX    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHARS_LO = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHARS_HI = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } ure_state_t;

  typedef struct packed {
    logic               done;
    logic [VALUE_W-1:0] quot;
    logic [DIGIT_W-1:0] rem;
  } div_res_t;

  function automatic logic [CHAR_W-1:0] char_for_digit(
    input logic [DIGIT_W-1:0] d,
    input logic [VALUE_W-1:0] lo,
    input logic [VALUE_W-1:0] hi
  );
    logic [VALUE_W-1:0] word;
    word = d[DIGIT_W-1] ? hi : lo;
    return word[{d[DIGIT_W-2:0], 3'b000} +: CHAR_W];
  endfunction

endpackage

[rtl/ure_ram.sv]
module ure_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/ure_div.sv]
module ure_div import ure_pkg::*; #(
  parameter int RADIX_W = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [VALUE_W-1:0] dividend,
  input  logic [RADIX_W-1:0] divisor,
  output div_res_t           res
);

  localparam int STEPS  = VALUE_W / DIV_STEP_BITS;
  localparam int STEP_W = $clog2(STEPS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [VALUE_W-1:0] work_r, work_nxt;
  logic [DIGIT_W-1:0] rem_r, rem_nxt;

  logic [DIGIT_W-1:0]       rem_chain;
  logic [DIGIT_W:0]         part;
  logic [DIV_STEP_BITS-1:0] q_bits;
  logic [DIV_STEP_BITS-1:0] chunk;

  // restoring division, DIV_STEP_BITS dividend bits per clock
  always_comb begin
    chunk     = work_r[VALUE_W-1 -: DIV_STEP_BITS];
    rem_chain = rem_r;
    q_bits    = '0;
    for (int i = 0; i < DIV_STEP_BITS; i++) begin
      part = {rem_chain, chunk[DIV_STEP_BITS-1-i]};
      if (part >= (DIGIT_W+1)'(divisor)) begin
        rem_chain = DIGIT_W'(part - (DIGIT_W+1)'(divisor));
        q_bits[DIV_STEP_BITS-1-i] = 1'b1;
      end else begin
        rem_chain = part[DIGIT_W-1:0];
      end
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    work_nxt = work_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      work_nxt = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      // quotient bits shift in as dividend bits shift out
      work_nxt = {work_r[VALUE_W-DIV_STEP_BITS-1:0], q_bits};
      rem_nxt  = rem_chain;
      step_nxt = step_r + 1'b1;
      if (step_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r <= work_nxt;
    rem_r  <= rem_nxt;
  end

  assign res.done = done_r;
  assign res.quot = work_r;
  assign res.rem  = rem_r;

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("divider done held longer than one cycle");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> ((DIGIT_W+1)'(rem_r) < (DIGIT_W+1)'(divisor)))
    else $error("divider remainder not below divisor");

endmodule

[rtl/unsigned_radix_digit_emitter.sv]
// writes one unsigned 64-bit value out in a configurable radix (2 to MAX_RADIX),
// most significant digit first, no leading zeros; zero gives one zero digit.
// each digit goes through a 16-entry byte table held in two config registers.
// a request is taken when start is high and busy is low; busy then stays high
// until the final digit has been sent. digits leave one per clock on out_valid
// with out_last_digit on the final one, and the receiver cannot stall them.
// each digit costs one pass of the shared divider, which retires 8 dividend
// bits per clock, then the digit stack memory is read back in reverse at one
// digit per clock.
// config writes (cfg_ready is always high) must only happen while busy is low.
module unsigned_radix_digit_emitter import ure_pkg::*; #(
  parameter int MAX_RADIX  = MAX_RADIX_DEF,
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // request
  input  logic                 start,
  output logic                 busy,
  input  logic [VALUE_W-1:0]   in_value,
  // digit stream
  output logic                 out_valid,
  output logic [CHAR_W-1:0]    out_digit_char,
  output logic                 out_last_digit,
  // configuration
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VALUE_W-1:0]   cfg_data
);

  localparam int RADIX_W = $clog2(MAX_RADIX + 1);
  localparam int ADDR_W  = $clog2(MAX_DIGITS);
  localparam int CNT_W   = $clog2(MAX_DIGITS + 1);
  localparam int RADIX_RST_CLAMP = (RADIX_RESET > MAX_RADIX) ? MAX_RADIX : RADIX_RESET;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_DIGITS);

  // configuration registers
  logic [RADIX_W-1:0] radix_r;
  logic [VALUE_W-1:0] chars_lo_r;
  logic [VALUE_W-1:0] chars_hi_r;
  logic [4:0]         radix_wr;

  // control state
  ure_state_t         state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;   // digits pushed on the stack
  logic [CNT_W-1:0]   k_r, k_nxt;           // digits left to read back
  logic               emit_v_r, emit_v_nxt;
  logic               emit_last_r, emit_last_nxt;

  // divider and stack hookup
  logic               div_start;
  logic [VALUE_W-1:0] div_dividend;
  div_res_t           div_res;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [DIGIT_W-1:0] ram_rdata;

  assign cfg_ready = 1'b1;

  // radix writes clamp to 2..MAX_RADIX so the divisor is never 0 or 1
  always_comb begin
    radix_wr = cfg_data[4:0];
    if (radix_wr < 5'd2) begin
      radix_wr = 5'd2;
    end else if (32'(radix_wr) > MAX_RADIX) begin
      radix_wr = 5'(MAX_RADIX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r    <= RADIX_W'(RADIX_RST_CLAMP);
      chars_lo_r <= CHARS_LO_RESET;
      chars_hi_r <= CHARS_HI_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_RADIX:    radix_r    <= RADIX_W'(radix_wr);
        CFG_CHARS_LO: chars_lo_r <= cfg_data;
        CFG_CHARS_HI: chars_hi_r <= cfg_data;
        default: ;    // unused index, write ignored
      endcase
    end
  end

  ure_div #(
    .RADIX_W (RADIX_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (radix_r),
    .res      (div_res)
  );

  // digit stack: least significant digit at address zero
  ure_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (MAX_DIGITS)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[ADDR_W-1:0]),
    .wdata (div_res.rem),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    k_nxt         = k_r;
    emit_v_nxt    = 1'b0;
    emit_last_nxt = 1'b0;
    div_start     = 1'b0;
    div_dividend  = div_res.quot;
    ram_we        = 1'b0;
    ram_raddr     = ADDR_W'(k_r - 1'b1);
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          div_start    = 1'b1;
          div_dividend = in_value;
          count_nxt    = '0;
          state_nxt    = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_res.done) begin
          // digits beyond the stack depth are the most significant: drop them
          if (count_r < CNT_MAX) begin
            ram_we    = 1'b1;
            count_nxt = count_r + 1'b1;
          end
          if (div_res.quot != '0) begin
            div_start = 1'b1;
          end else begin
            k_nxt     = count_nxt;
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        // read address goes out in the cycle before the digit appears
        if (k_r != '0) begin
          emit_v_nxt    = 1'b1;
          emit_last_nxt = (k_r == CNT_W'(1));
          k_nxt         = k_r - 1'b1;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      k_r         <= '0;
      emit_v_r    <= 1'b0;
      emit_last_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      k_r         <= k_nxt;
      emit_v_r    <= emit_v_nxt;
      emit_last_r <= emit_last_nxt;
    end
  end

  assign busy           = (state_r != ST_IDLE);
  assign out_valid      = emit_v_r;
  assign out_last_digit = emit_last_r;
  assign out_digit_char = char_for_digit(ram_rdata, chars_lo_r, chars_hi_r);

  a_req_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request taken but busy not raised");

  a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_digit) |=> (!busy && !out_valid))
    else $error("activity after the last digit");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r <= CNT_MAX) && (k_r <= count_r || state_r != ST_EMIT))
    else $error("digit count out of range");

  a_valid_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_r == ST_EMIT))
    else $error("digit strobe outside the emit phase");

endmodule
